### rtl/core/bsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_pkg
// Types, constants and character helpers shared by the escape decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

	localparam int WIN_DEPTH = 10;
	localparam int CNT_W     = 4;
	localparam int IDX_W     = 5;
	localparam int NL_LEN    = 11;
	localparam int CR_LEN    = 18;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [0:NL_LEN-1][7:0] NL_TEXT = "__NEWLINE__";
	localparam logic [0:CR_LEN-1][7:0] CR_TEXT = "__CARRIAGERETURN__";

	// source of the bytes an escape emits
	localparam logic [1:0] SRC_W0  = 2'd0;
	localparam logic [1:0] SRC_NL  = 2'd1;
	localparam logic [1:0] SRC_CR  = 2'd2;
	localparam logic [1:0] SRC_VAL = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		logic       run_last;
	} out_word_t;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;

	typedef struct packed {
		logic             hold;
		logic [IDX_W-1:0] emit_n;
		logic [CNT_W-1:0] drop_n;
		logic [1:0]       src;
		logic [2:0][7:0]  val;
	} esc_dec_t;

	function automatic logic is_dig(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_dig(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
	endfunction

	function automatic logic [3:0] hexv(input logic [7:0] b);
		logic [7:0] t;
		t = 8'h00;
		if (is_dig(b))
			t = b - "0";
		else if ((b >= "a") && (b <= "f"))
			t = b - "a" + 8'd10;
		else if ((b >= "A") && (b <= "F"))
			t = b - "A" + 8'd10;
		return t[3:0];
	endfunction

	function automatic logic digit_ok(input logic [7:0] kind, input logic [7:0] b);
		logic ok;
		ok = 1'b0;
		if (kind == "x" || kind == "u")
			ok = is_hex(b);
		else if (kind == "o")
			ok = (b >= "0") && (b <= "7");
		else if (kind == "d")
			ok = is_dig(b);
		else if (kind == "b")
			ok = (b == "0") || (b == "1");
		return ok;
	endfunction

endpackage
`default_nettype wire

### rtl/core/bsd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_front
// Input side: accepts words into a two-entry queue ahead of the decoder.
// ----------------------------------------------------------------------------
module bsd_front import bsd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_word_t in_data,
	output logic          q_valid,
	output in_word_t      q_data,
	input  wire logic     q_pop
);

	in_word_t   slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;

	assign in_stall = (fill_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != 2'd0);
	assign q_data   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			fill_q <= fill_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule
`default_nettype wire

### rtl/core/bsd_esc_dec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_esc_dec
// Decides the escape at the head of the window: wait, fail, or what to emit
// and how many bytes to drop.
// ----------------------------------------------------------------------------
module bsd_esc_dec import bsd_pkg::*; (
	input  wire win_t             win,
	input  wire logic [CNT_W-1:0] cnt,
	input  wire logic             ended,
	output esc_dec_t              dec
);

	always_comb begin
		logic [7:0]       kind;
		logic [CNT_W-1:0] len;
		logic             bad;
		logic [9:0]       dv;
		logic [15:0]      uv;

		// default: failed escape, emit head byte and drop it
		dec.hold   = 1'b0;
		dec.emit_n = IDX_W'(1);
		dec.drop_n = CNT_W'(1);
		dec.src    = SRC_W0;
		dec.val    = '0;

		kind = win[1];
		if (kind == "x")
			len = CNT_W'(4);
		else if (kind == "o" || kind == "d")
			len = CNT_W'(5);
		else if (kind == "b")
			len = CNT_W'(10);
		else if (kind == "u")
			len = CNT_W'(6);
		else
			len = '0;

		bad = 1'b0;
		for (int j = 2; j < WIN_DEPTH; j++) begin
			if ((CNT_W'(j) < cnt) && (CNT_W'(j) < len) && !digit_ok(kind, win[j]))
				bad = 1'b1;
		end

		dv = 10'(win[2][3:0]) * 10'd100 + 10'(win[3][3:0]) * 10'd10
			+ 10'(win[4][3:0]);
		uv = {hexv(win[2]), hexv(win[3]), hexv(win[4]), hexv(win[5])};

		if (win[0] != CH_BSLASH) begin
			// plain byte passes through, defaults stand
		end else if (cnt < CNT_W'(2)) begin
			if (!ended)
				dec.hold = 1'b1;
		end else if (kind == "n") begin
			dec.emit_n = IDX_W'(NL_LEN);
			dec.drop_n = CNT_W'(2);
			dec.src    = SRC_NL;
		end else if (kind == "r") begin
			dec.emit_n = IDX_W'(CR_LEN);
			dec.drop_n = CNT_W'(2);
			dec.src    = SRC_CR;
		end else if (kind == "t") begin
			dec.drop_n = CNT_W'(2);
			dec.src    = SRC_VAL;
			dec.val[0] = CH_TAB;
		end else if (kind == "0") begin
			if (cnt < CNT_W'(3)) begin
				if (!ended) begin
					dec.hold = 1'b1;
				end else begin
					dec.emit_n = '0;
					dec.drop_n = CNT_W'(2);
				end
			end else if (!is_dig(win[2])) begin
				dec.emit_n = '0;
				dec.drop_n = CNT_W'(2);
			end
		end else if (len == '0 || bad) begin
			// fail, defaults stand
		end else if (cnt < len) begin
			if (!ended)
				dec.hold = 1'b1;
		end else if (kind == "d" && dv > 10'd255) begin
			// decimal out of range fails
		end else begin
			dec.drop_n = len;
			dec.src    = SRC_VAL;
			if (kind == "x") begin
				dec.val[0] = {hexv(win[2]), hexv(win[3])};
			end else if (kind == "o") begin
				dec.val[0] = {win[2][1:0], win[3][2:0], win[4][2:0]};
			end else if (kind == "d") begin
				dec.val[0] = dv[7:0];
			end else if (kind == "b") begin
				dec.val[0] = {win[2][0], win[3][0], win[4][0], win[5][0],
					win[6][0], win[7][0], win[8][0], win[9][0]};
			end else begin
				if (uv < 16'h0080) begin
					dec.val[0] = uv[7:0];
				end else if (uv < 16'h0800) begin
					dec.emit_n = IDX_W'(2);
					dec.val[0] = 8'hC0 | {3'b000, uv[10:6]};
					dec.val[1] = 8'h80 | {2'b00, uv[5:0]};
				end else begin
					dec.emit_n = IDX_W'(3);
					dec.val[0] = 8'hE0 | {4'h0, uv[15:12]};
					dec.val[1] = 8'h80 | {2'b00, uv[11:6]};
					dec.val[2] = 8'h80 | {2'b00, uv[5:0]};
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/bsd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_back
// Window engine: appends each word, resolves escapes one byte per cycle while
// the output is not stalled, and drives the registered output. The last byte is
// held back so it can carry run_last.
// ----------------------------------------------------------------------------
module bsd_back import bsd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_valid,
	input  wire in_word_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_word_t     out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	win_t             win_q, win_d, win_sh;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_sh;
	logic             ended_q, ended_d;
	logic [1:0]       st_q, st_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0]       hold_q, hold_d;
	logic             hold_v_q, hold_v_d;
	logic             out_v_q;
	out_word_t        out_q;

	esc_dec_t         dec;
	logic             push_ok;
	logic             push;
	out_word_t        push_word;
	logic [7:0]       cur_byte;

	bsd_esc_dec u_dec (
		.win   (win_q),
		.cnt   (cnt_q),
		.ended (ended_q),
		.dec   (dec)
	);

	assign push_ok   = !out_v_q || !out_stall;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_comb begin
		unique case (dec.src)
			SRC_W0:  cur_byte = win_q[0];
			SRC_NL:  cur_byte = NL_TEXT[idx_q[3:0]];
			SRC_CR:  cur_byte = CR_TEXT[idx_q];
			SRC_VAL: cur_byte = dec.val[idx_q[1:0]];
			default: cur_byte = win_q[0];
		endcase
	end

	// window after dropping the bytes the current escape consumed
	always_comb begin
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (i + int'(dec.drop_n) < WIN_DEPTH)
				win_sh[i] = win_q[CNT_W'(i + int'(dec.drop_n))];
			else
				win_sh[i] = win_q[i];
		end
		cnt_sh = (dec.drop_n > cnt_q) ? '0 : cnt_q - dec.drop_n;
	end

	always_comb begin
		win_d     = win_q;
		cnt_d     = cnt_q;
		ended_d   = ended_q;
		st_d      = st_q;
		idx_d     = idx_q;
		hold_d    = hold_q;
		hold_v_d  = hold_v_q;
		q_pop     = 1'b0;
		push      = 1'b0;
		push_word = '0;

		unique case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					ended_d = q_data.in_last;
					if (cnt_q < CNT_W'(WIN_DEPTH)) begin
						win_d[cnt_q] = q_data.in_byte;
						cnt_d        = cnt_q + CNT_W'(1);
					end
					st_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == '0 || dec.hold) begin
					st_d = ST_FIN;
				end else if (dec.emit_n == '0) begin
					win_d = win_sh;
					cnt_d = cnt_sh;
				end else if (!hold_v_q || push_ok) begin
					if (hold_v_q) begin
						push      = 1'b1;
						push_word = '{out_byte: hold_q, byte_valid: 1'b1,
							string_end: 1'b0, run_last: 1'b0};
					end
					hold_d   = cur_byte;
					hold_v_d = 1'b1;
					if (idx_q == dec.emit_n - IDX_W'(1)) begin
						idx_d = '0;
						win_d = win_sh;
						cnt_d = cnt_sh;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			ST_FIN: begin
				if (hold_v_q) begin
					if (push_ok) begin
						push      = 1'b1;
						push_word = '{out_byte: hold_q, byte_valid: 1'b1,
							string_end: ended_q, run_last: 1'b1};
						hold_v_d  = 1'b0;
						if (ended_q)
							cnt_d = '0;
						st_d = ST_IDLE;
					end
				end else if (ended_q) begin
					if (push_ok) begin
						// bare end marker
						push      = 1'b1;
						push_word = '{out_byte: 8'h00, byte_valid: 1'b0,
							string_end: 1'b1, run_last: 1'b1};
						cnt_d     = '0;
						st_d      = ST_IDLE;
					end
				end else begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		win_q  <= win_d;
		hold_q <= hold_d;
		if (push)
			out_q <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ended_q  <= 1'b0;
			st_q     <= ST_IDLE;
			idx_q    <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			cnt_q    <= cnt_d;
			ended_q  <= ended_d;
			st_q     <= st_d;
			idx_q    <= idx_d;
			hold_v_q <= hold_v_d;
			if (push)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/core/backslash_escape_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top
// Decodes backslash escapes in a byte stream; a two-entry input queue feeds
// the window engine, which drives a registered output.
// ----------------------------------------------------------------------------
// A word is accepted into the queue, popped by the engine in its idle state and
// appended to the window; the engine then resolves escapes in its scan state and
// sends the held-back last byte in its finish state. A new word is popped only
// once the engine is back in idle, and a stalled output holds the engine.
// Reset clears the queue, window count and output valid; window bytes are
// not cleared.
module backslash_escape_decoder_top import bsd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_word_t in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_word_t     out_data
);

	logic     q_valid;
	in_word_t q_data;
	logic     q_pop;

	bsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop)
	);

	bsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

### tb/backslash_escape_decoder_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// backslash_escape_decoder_checker
// Watches both channels of the escape decoder, predicts the decoded words
// for every accepted input word and compares them in order.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_checker import bsd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_stall,
	input  wire in_word_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_stall,
	input  wire out_word_t out_data,
	output int             fail_count,
	output int             pending_count,
	output int             word_count,
	output int             string_count
);

	localparam logic [7:0] BSLASH = 8'h5C;

	logic [7:0] pend_bytes[$];
	logic [7:0] dec_bytes[$];
	out_word_t  expected_words[$];

	function automatic logic dig(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic [3:0] nib(input logic [7:0] b);
		if (dig(b))
			return 4'(b - 8'h30);
		if (b >= 8'h61 && b <= 8'h66)
			return 4'(b - 8'h57);
		return 4'(b - 8'h37);
	endfunction

	function automatic logic good_digit(input logic [7:0] k, input logic [7:0] b);
		case (k)
			8'h78, 8'h75: return dig(b) || (b >= 8'h61 && b <= 8'h66)
				|| (b >= 8'h41 && b <= 8'h46);
			8'h6F: return b >= 8'h30 && b <= 8'h37;
			8'h64: return dig(b);
			8'h62: return b == 8'h30 || b == 8'h31;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void put(input logic [7:0] b);
		if (dec_bytes.size() < 18)
			dec_bytes = {dec_bytes, b};
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endfunction

	function automatic void drop_front(input int k);
		for (int i = 0; i < k && pend_bytes.size() > 0; i++)
			void'(pend_bytes.pop_front());
	endfunction

	function automatic void pass_backslash();
		put(pend_bytes[0]);
		drop_front(1);
	endfunction

	// returns 0 when the escape needs more bytes
	function automatic logic decode_escape(input logic ended);
		int n, len;
		logic [7:0] k;
		int v;
		n = pend_bytes.size();
		if (n < 2) begin
			if (!ended)
				return 1'b0;
			pass_backslash();
			return 1'b1;
		end
		k = pend_bytes[1];
		len = 0;
		case (k)
			8'h6E: begin put_text("__NEWLINE__"); drop_front(2); return 1'b1; end
			8'h72: begin put_text("__CARRIAGERETURN__"); drop_front(2); return 1'b1; end
			8'h74: begin put(CH_TAB); drop_front(2); return 1'b1; end
			8'h30: begin
				if (n < 3) begin
					if (!ended)
						return 1'b0;
					drop_front(2);
				end else if (dig(pend_bytes[2]))
					pass_backslash();
				else
					drop_front(2);
				return 1'b1;
			end
			8'h78: len = 4;
			8'h6F: len = 5;
			8'h64: len = 5;
			8'h62: len = 10;
			8'h75: len = 6;
			default: begin pass_backslash(); return 1'b1; end
		endcase
		for (int j = 2; j < n && j < len; j++)
			if (!good_digit(k, pend_bytes[j])) begin
				pass_backslash();
				return 1'b1;
			end
		if (n < len) begin
			if (!ended)
				return 1'b0;
			pass_backslash();
			return 1'b1;
		end
		v = 0;
		case (k)
			8'h78: put({nib(pend_bytes[2]), nib(pend_bytes[3])});
			8'h6F: put(8'((pend_bytes[2] - 8'h30) * 64 + (pend_bytes[3] - 8'h30) * 8
				+ (pend_bytes[4] - 8'h30)));
			8'h64: begin
				v = (pend_bytes[2] - 8'h30) * 100 + (pend_bytes[3] - 8'h30) * 10
					+ (pend_bytes[4] - 8'h30);
				if (v > 255) begin
					pass_backslash();
					return 1'b1;
				end
				put(8'(v));
			end
			8'h62: begin
				for (int j = 2; j < 10; j++)
					v = (v << 1) | (pend_bytes[j] == 8'h31);
				put(8'(v));
			end
			default: begin
				for (int j = 2; j < 6; j++)
					v = (v << 4) | nib(pend_bytes[j]);
				if (v < 'h80)
					put(8'(v));
				else if (v < 'h800) begin
					put(8'(8'hC0 | (v >> 6)));
					put(8'(8'h80 | (v & 'h3F)));
				end else begin
					put(8'(8'hE0 | (v >> 12)));
					put(8'(8'h80 | ((v >> 6) & 'h3F)));
					put(8'(8'h80 | (v & 'h3F)));
				end
			end
		endcase
		drop_front(len);
		return 1'b1;
	endfunction

	task automatic decode_word(input in_word_t w);
		out_word_t r;
		dec_bytes.delete();
		if (pend_bytes.size() < WIN_DEPTH)
			pend_bytes = {pend_bytes, w.in_byte};
		while (pend_bytes.size() > 0) begin
			if (pend_bytes[0] != BSLASH) begin
				put(pend_bytes[0]);
				drop_front(1);
			end else if (!decode_escape(w.in_last))
				break;
		end
		if (w.in_last) begin
			pend_bytes.delete();
			string_count++;
			if (dec_bytes.size() == 0) begin
				r = '{out_byte: 8'h00, byte_valid: 1'b0, string_end: 1'b1, run_last: 1'b1};
				expected_words = {expected_words, r};
			end
		end
		foreach (dec_bytes[i]) begin
			r.out_byte   = dec_bytes[i];
			r.byte_valid = 1'b1;
			r.run_last   = (i == dec_bytes.size() - 1);
			r.string_end = w.in_last && r.run_last;
			expected_words = {expected_words, r};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			fail_count    <= 0;
			word_count    <= 0;
			string_count  = 0;
			pend_bytes.delete();
			expected_words.delete();
		end else begin
			if (in_valid && !in_stall)
				decode_word(in_data);
			if (out_valid && !out_stall) begin
				word_count <= word_count + 1;
				if (expected_words.size() == 0) begin
					if (fail_count < 10)
						$display("MISMATCH unexpected word %p", out_data);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_words.pop_front();
					if (out_data !== e) begin
						if (fail_count < 10)
							$display("MISMATCH expected %p actual %p", e, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending_count = expected_words.size();

endmodule
`default_nettype wire

### tb/backslash_escape_decoder_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top_tb
// Feeds directed and random escape strings with random idling on both sides;
// the checker predicts and compares every decoded word.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_top_tb;
	import bsd_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;
	int        fail_count, pending_count, word_count, string_count;
	logic      calm = 1'b0;
	logic      hold_rx = 1'b0;
	int        items_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	backslash_escape_decoder_top u_top (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data
	);

	backslash_escape_decoder_checker u_chk (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.fail_count, .pending_count, .word_count, .string_count
	);

	// one word per call; sometimes a random gap before it
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{in_byte: b, in_last: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] digit_of(input int k);
		string hx;
		hx = "0123456789abcdefABCDEF";
		case (k)
			0: return 8'(8'h30 + $urandom_range(0, 7));
			1: return 8'(8'h30 + $urandom_range(0, 9));
			2: return 8'(8'h30 + $urandom_range(0, 1));
			default: return hx[$urandom_range(0, 21)];
		endcase
	endfunction

	// a random string biased toward well-formed escapes
	task automatic send_random_string();
		string s, kinds;
		int n, sel;
		kinds = "nrt0xodbu";
		s = "";
		n = $urandom_range(1, 4);
		for (int p = 0; p < n; p++) begin
			sel = $urandom_range(0, 9);
			if (sel < 2)
				s = {s, string'(8'($urandom_range(0, 255)))};
			else begin
				s = {s, "\\", string'(kinds[$urandom_range(0, 8)])};
				case (s[s.len()-1])
					"x": for (int j = 0; j < 2; j++) s = {s, string'(digit_of(3))};
					"o": for (int j = 0; j < 3; j++) s = {s, string'(digit_of(0))};
					"d": begin
						s = {s, string'(8'(8'h30 + $urandom_range(0, 2)))};
						for (int j = 0; j < 2; j++) s = {s, string'(digit_of(1))};
					end
					"b": for (int j = 0; j < 8; j++) s = {s, string'(digit_of(2))};
					"u": for (int j = 0; j < 4; j++) s = {s, string'(digit_of(3))};
					"0": if ($urandom_range(0, 1)) s = {s, string'(digit_of(1))};
					default: ;
				endcase
				// occasionally corrupt or truncate the escape
				if ($urandom_range(0, 7) == 0 && s.len() > 2)
					s[$urandom_range(2, s.len() - 1)] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 9) == 0)
					s = s.substr(0, s.len() - 2);
			end
		end
		// empty string bytes (0x00) are fine; keep length at least one
		if (s.len() == 0)
			s = "a";
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// receiver side stalls
	initial begin
		int gap;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx)
				out_stall <= 1'b1;
			else if (!calm && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 11);
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end else
				out_stall <= 1'b0;
		end
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int hold_cycles;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_string("plain");
		send_string("\\n\\r\\t");
		send_string("\\0");
		send_string("\\05\\0a");
		send_string("\\xfF\\x0G");
		send_string("\\o777\\o8");
		send_string("\\d255\\d256");
		send_string("\\b10100101");
		send_string("\\u007f\\u07FF\\uffff");
		send_string("\\q\\x4");
		send_string("\\");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		// long receiver hold while words keep coming in
		hold_rx = 1'b1;
		fork
			begin
				hold_cycles = 0;
				while (hold_cycles < 200) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_rx = 1'b0;
			end
			send_string("\\r\\r\\n\\r");
		join

		while (items_sent < 240)
			send_random_string();
		calm = 1'b1;
		while (items_sent < 300)
			send_random_string();
		in_valid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d bytes in %0d strings; checked %0d decoded words.",
			items_sent, string_count, word_count);
		if (fail_count == 0 && pending_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
rtl/core/bsd_pkg.sv
rtl/core/bsd_front.sv
rtl/core/bsd_esc_dec.sv
rtl/core/bsd_back.sv
rtl/core/backslash_escape_decoder_top.sv
tb/backslash_escape_decoder_checker.sv
tb/backslash_escape_decoder_top_tb.sv
